@@ design/sds_pkg.sv @@
// Shared types and constants for the sprite distance sort block.
package sds_pkg;

	localparam int MAX_OBJECTS = 32;
	localparam int CNT_W       = $clog2(MAX_OBJECTS + 1);
	localparam int IDX_W       = $clog2(MAX_OBJECTS);

	localparam int POS_W      = 24;
	localparam int SQ_W       = 2 * POS_W;
	localparam int DIST_W     = SQ_W + 1;
	localparam int IN_DATA_W  = 2 * POS_W;
	localparam int OUT_FLD_W  = 2 * POS_W + DIST_W;
	localparam int OUT_DATA_W = ((OUT_FLD_W + 7) / 8) * 8;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VIEWER_Y = 2'd1;

	typedef struct packed {
		logic [POS_W-1:0]  x;
		logic [POS_W-1:0]  y;
		logic [DIST_W-1:0] d;
	} entry_t;

	typedef struct packed {
		logic   valid;
		logic   last;
		entry_t e;
	} item_t;

	typedef struct packed {
		logic             insert;
		logic             shift;
		logic [CNT_W-1:0] count;
	} cell_ctrl_t;

endpackage

@@ design/sds_dist.sv @@
// Squared distance pipeline: difference, magnitude, squares, sum.
module sds_dist import sds_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [POS_W-1:0] obj_x,
	input  logic [POS_W-1:0] obj_y,
	input  logic             in_last,
	input  logic [POS_W-1:0] viewer_x,
	input  logic [POS_W-1:0] viewer_y,
	output item_t            item
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              l_s1, l_s2, l_s3, l_s4;
	logic [POS_W-1:0]  x_s1, x_s2, x_s3, x_s4;
	logic [POS_W-1:0]  y_s1, y_s2, y_s3, y_s4;
	logic signed [POS_W:0] dx_s1, dy_s1;
	logic [POS_W-1:0]  ax_s2, ay_s2;
	logic [SQ_W-1:0]   sqx_s3, sqy_s3;
	logic [DIST_W-1:0] d_s4;
	logic [POS_W:0]    ndx, ndy;

	assign ndx = -dx_s1;
	assign ndy = -dy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1 <= $signed({viewer_x[POS_W-1], viewer_x}) - $signed({obj_x[POS_W-1], obj_x});
		dy_s1 <= $signed({viewer_y[POS_W-1], viewer_y}) - $signed({obj_y[POS_W-1], obj_y});
		x_s1  <= obj_x;
		y_s1  <= obj_y;
		l_s1  <= in_last;

		// |diff| stays below 2^24, so the low bits hold the magnitude
		ax_s2 <= dx_s1[POS_W] ? ndx[POS_W-1:0] : dx_s1[POS_W-1:0];
		ay_s2 <= dy_s1[POS_W] ? ndy[POS_W-1:0] : dy_s1[POS_W-1:0];
		x_s2  <= x_s1;
		y_s2  <= y_s1;
		l_s2  <= l_s1;

		sqx_s3 <= SQ_W'(ax_s2) * SQ_W'(ax_s2);
		sqy_s3 <= SQ_W'(ay_s2) * SQ_W'(ay_s2);
		x_s3   <= x_s2;
		y_s3   <= y_s2;
		l_s3   <= l_s2;

		d_s4 <= {1'b0, sqx_s3} + {1'b0, sqy_s3};
		x_s4 <= x_s3;
		y_s4 <= y_s3;
		l_s4 <= l_s3;
	end

	assign item.valid = v_s4;
	assign item.last  = l_s4;
	assign item.e.x   = x_s4;
	assign item.e.y   = y_s4;
	assign item.e.d   = d_s4;

endmodule

@@ design/sds_cell.sv @@
// One slot of the insertion chain: holds an entry, inserts in order, shifts out.
module sds_cell import sds_pkg::*; (
	input  logic             clk,
	input  cell_ctrl_t       ctrl,
	input  logic [IDX_W-1:0] idx,
	input  entry_t           new_e,
	input  entry_t           prev_e,
	input  logic             prev_keep,
	input  entry_t           next_e,
	output entry_t           e,
	output logic             keep
);

	entry_t e_q;

	// occupied and at least as far as the newcomer: stays in place
	assign keep = (CNT_W'(idx) < ctrl.count) && (e_q.d >= new_e.d);
	assign e    = e_q;

	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!keep) begin
				e_q <= prev_keep ? new_e : prev_e;
			end
		end else if (ctrl.shift) begin
			e_q <= next_e;
		end
	end

endmodule

@@ design/sprite_distance_sort_desc_core.sv @@
// Top level: config registers, distance pipeline, insertion chain, output register.
// Each object enters at one item per cycle while s_tready is high; it passes the four distance
// stages (difference, magnitude, squares, sum) and is then inserted into the cell chain.
// After the last item has been inserted, results follow one per cycle while m_tready does not
// stall the output register, shifted out of cell 0; input is held off from the last accepted item until the
// chain is empty. Reset (arst_n low) clears counts, flags and viewer registers.
module sprite_distance_sort_desc_core import sds_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [IN_DATA_W-1:0]  s_tdata,   // object_x, object_y
	input  logic                  s_tlast,   // last_in
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,   // sorted_x, sorted_y, squared_distance, zero pad
	output logic                  m_tlast,   // last_out
	output logic                  m_tuser,   // dropped
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [POS_W-1:0]      cfg_data
);

	logic [POS_W-1:0] viewer_x_q, viewer_y_q;
	logic [CNT_W-1:0] count_q;
	logic             overflow_q;
	logic             hold_q;
	logic             drain_q;
	logic             out_valid_q;
	logic             out_last_q;
	logic             out_drop_q;
	entry_t           out_e_q;

	item_t              item;
	cell_ctrl_t         ctrl;
	entry_t             cell_e [MAX_OBJECTS];
	logic [MAX_OBJECTS-1:0] cell_keep;
	logic               in_acc;
	logic               full;
	logic               move;

	assign cfg_ready = 1'b1;
	assign s_tready  = !hold_q;
	assign in_acc    = s_tvalid && s_tready;
	assign full      = (count_q == CNT_W'(MAX_OBJECTS));
	assign move      = drain_q && (!out_valid_q || m_tready);

	assign ctrl.insert = item.valid && !full;
	assign ctrl.shift  = move;
	assign ctrl.count  = count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			viewer_x_q <= '0;
			viewer_y_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_VIEWER_X: viewer_x_q <= cfg_data;
				REG_VIEWER_Y: viewer_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	sds_dist u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_acc),
		.obj_x    (s_tdata[POS_W-1:0]),
		.obj_y    (s_tdata[2*POS_W-1:POS_W]),
		.in_last  (s_tlast),
		.viewer_x (viewer_x_q),
		.viewer_y (viewer_y_q),
		.item     (item)
	);

	for (genvar i = 0; i < MAX_OBJECTS; i++) begin : g_cell
		entry_t prev_e, next_e;
		logic   prev_keep;
		if (i == 0) begin : g_first
			assign prev_e    = item.e;
			assign prev_keep = 1'b0;
		end else begin : g_mid
			assign prev_e    = cell_e[i-1];
			assign prev_keep = cell_keep[i-1];
		end
		if (i == MAX_OBJECTS - 1) begin : g_end
			assign next_e = item.e;
		end else begin : g_inner
			assign next_e = cell_e[i+1];
		end
		sds_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.idx       (IDX_W'(i)),
			.new_e     (item.e),
			.prev_e    (prev_e),
			.prev_keep (prev_keep),
			.next_e    (next_e),
			.e         (cell_e[i]),
			.keep      (cell_keep[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			overflow_q  <= 1'b0;
			hold_q      <= 1'b0;
			drain_q     <= 1'b0;
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			out_drop_q  <= 1'b0;
		end else begin
			if (in_acc && s_tlast) begin
				hold_q <= 1'b1;
			end
			if (item.valid) begin
				if (full) begin
					overflow_q <= 1'b1;
				end else begin
					count_q <= count_q + CNT_W'(1);
				end
				if (item.last) begin
					drain_q <= 1'b1;
				end
			end
			if (move) begin
				out_valid_q <= 1'b1;
				out_last_q  <= (count_q == CNT_W'(1));
				out_drop_q  <= overflow_q;
				count_q     <= count_q - CNT_W'(1);
				if (count_q == CNT_W'(1)) begin
					drain_q    <= 1'b0;
					hold_q     <= 1'b0;
					overflow_q <= 1'b0;
				end
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move) begin
			out_e_q <= cell_e[0];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_drop_q;
	assign m_tdata  = OUT_DATA_W'({out_e_q.d, out_e_q.y, out_e_q.x});

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_OBJECTS))
		else $error("entry count above capacity");

	a_no_input_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !s_tready)
		else $error("input ready while draining");

	a_overflow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(overflow_q) |-> $past(count_q) == CNT_W'(MAX_OBJECTS))
		else $error("overflow flagged while store not full");

	a_drain_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(move && count_q == CNT_W'(1)) |=> (!drain_q && count_q == '0 && m_tvalid && m_tlast))
		else $error("drain did not end on final item");

	a_no_insert_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> !item.valid)
		else $error("insertion during drain");
`endif

endmodule
